// File: hdl/fpr_pkg.sv
// shared types and constants for the fifo page replacement block
// no dependencies; imported by fpr_cell and fifo_page_replacement
`default_nettype none
package fpr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int SLOT_W    = 3;
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 32;
	localparam int ADDR_W    = 3;

	localparam logic [CNT_W-1:0] FRAMES_RESET = 4'd8;
	localparam logic [0:0]       REG_FRAMES_IN_USE = 1'b0;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [SLOT_W-1:0]    slot_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic  hit;
		slot_t hit_slot;
		logic  ev_valid;
		page_t ev_page;
	} fpr_chain_t;

	// per-transaction control broadcast to every cell
	typedef struct packed {
		logic write;
		logic clear;
	} fpr_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/fpr_cell.sv
// one page frame: stored page, valid bit, compare and chain stage
// depends on fpr_pkg
`default_nettype none
module fpr_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpr_pkg::slot_t     idx,
	input  wire logic               enable,
	input  wire logic               victim,
	input  wire fpr_pkg::page_t     page,
	input  wire fpr_pkg::fpr_ctrl_t ctrl,
	input  wire fpr_pkg::fpr_chain_t chain_in,
	output fpr_pkg::fpr_chain_t     chain_out
);
	import fpr_pkg::*;

	page_t page_q;
	logic  valid_q;
	logic  match;

	assign match = enable && valid_q && (page_q == page);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.hit && match) begin
			chain_out.hit      = 1'b1;
			chain_out.hit_slot = idx;
		end
		if (victim) begin
			chain_out.ev_valid = valid_q;
			chain_out.ev_page  = valid_q ? page_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.write && victim) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.write && victim && !ctrl.clear) begin
			page_q <= page;
		end
	end

endmodule
`default_nettype wire

// File: hdl/fifo_page_replacement.sv
// top level of the fifo page replacement block: row of frame cells,
// victim pointer, fault counter, output register and register port
// depends on fpr_pkg and fpr_cell
//
//   channel   handshake               payload
//   in        in_valid / in_stall     page_number, end_of_sequence
//   out       out_valid / out_stall   page_fault, frame_slot, evicted_valid,
//                                     evicted_page, fault_count
//   cfg       psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// one transaction per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance
// the compare ripples through the row of frame cells within the accepting cycle
// reset empties all frames and sets frames_in_use to 8
// in_stall follows out_stall while a result is held in the output register
`default_nettype none
module fifo_page_replacement (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fpr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [fpr_pkg::CFG_W-1:0]   pwdata,
	output logic      [fpr_pkg::CFG_W-1:0]   prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [fpr_pkg::PAGE_BITS-1:0] page_number,
	input  wire logic                        end_of_sequence,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             page_fault,
	output logic      [fpr_pkg::SLOT_W-1:0]  frame_slot,
	output logic                             evicted_valid,
	output logic      [fpr_pkg::PAGE_BITS-1:0] evicted_page,
	output logic      [15:0]                 fault_count
);
	import fpr_pkg::*;

	logic [CNT_W-1:0] frames_q;
	logic [CNT_W-1:0] count;
	slot_t            ptr_q;
	slot_t            ptr_eff;
	logic [CNT_W-1:0] ptr_inc;
	slot_t            ptr_next;
	logic [15:0]      fault_q;
	logic [15:0]      fault_next;
	logic             accept;
	logic             miss;
	fpr_ctrl_t        ctrl;
	fpr_chain_t       chain [FRAMES+1];

	logic             out_valid_q;
	logic             page_fault_q;
	slot_t            frame_slot_q;
	logic             evicted_valid_q;
	page_t            evicted_page_q;
	logic [15:0]      fault_count_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? CFG_W'(frames_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (psel && penable && pwrite && pready
		             && paddr[2] == REG_FRAMES_IN_USE) begin
			frames_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		if (frames_q == '0) begin
			count = CNT_W'(1);
		end else if (frames_q > CNT_W'(FRAMES)) begin
			count = CNT_W'(FRAMES);
		end else begin
			count = frames_q;
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign ptr_eff  = ({1'b0, ptr_q} >= count) ? '0 : ptr_q;
	assign ptr_inc  = {1'b0, ptr_eff} + CNT_W'(1);
	assign ptr_next = (ptr_inc >= count) ? '0 : ptr_inc[SLOT_W-1:0];

	assign miss       = !chain[FRAMES].hit;
	assign fault_next = (fault_q == 16'hFFFF) ? fault_q : fault_q + 16'd1;

	assign ctrl.write = accept && miss;
	assign ctrl.clear = accept && end_of_sequence;

	assign chain[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		fpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (SLOT_W'(i)),
			.enable    (CNT_W'(i) < count),
			.victim    (ptr_eff == SLOT_W'(i)),
			.page      (page_number),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			fault_q <= '0;
		end else if (accept) begin
			if (end_of_sequence) begin
				ptr_q   <= '0;
				fault_q <= '0;
			end else if (miss) begin
				ptr_q   <= ptr_next;
				fault_q <= fault_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_fault_q    <= miss;
			frame_slot_q    <= miss ? ptr_eff : chain[FRAMES].hit_slot;
			evicted_valid_q <= miss && chain[FRAMES].ev_valid;
			evicted_page_q  <= (miss && chain[FRAMES].ev_valid) ?
			                   chain[FRAMES].ev_page : '0;
			fault_count_q   <= miss ? fault_next : fault_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign page_fault    = page_fault_q;
	assign frame_slot    = frame_slot_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_count   = fault_count_q;

endmodule
`default_nettype wire
